// ===== hdl/contiguous_slot_allocator_assert.svh =====
// Assertion macros for the contiguous slot allocator.
`ifndef CONTIGUOUS_SLOT_ALLOCATOR_ASSERT_SVH
`define CONTIGUOUS_SLOT_ALLOCATOR_ASSERT_SVH

// Plain property, sampled on clk_i, off during reset.
`define CSA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define CSA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/csa_pkg.sv =====
// Shared constants, codes and types for the contiguous slot allocator.
package csa_pkg;

  localparam int unsigned NumSlots = 64;
  localparam int unsigned SlotW    = $clog2(NumSlots);
  localparam int unsigned CntW     = SlotW + 1;
  localparam int unsigned BytesW   = 18;
  localparam int unsigned SizeW    = 13;
  localparam int unsigned ProdW    = CntW + SizeW;
  localparam int unsigned DivCntW  = $clog2(BytesW + 1);

  localparam logic [SizeW-1:0]  SizeReset = SizeW'(64);
  localparam logic [SizeW-1:0]  SizeMin   = SizeW'(1);
  localparam logic [SizeW-1:0]  SizeMax   = SizeW'(4096);
  localparam logic [BytesW-1:0] BytesMax  = {BytesW{1'b1}};

  typedef enum logic [1:0] {
    STATUS_DONE     = 2'd0,
    STATUS_NO_ROOM  = 2'd1,
    STATUS_BAD_FREE = 2'd2
  } status_e;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  typedef struct packed {
    logic              start;
    logic [BytesW-1:0] dividend;
    logic [SizeW-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [BytesW-1:0] quot;
    logic [SizeW-1:0]  rem;
  } div_rsp_t;

endpackage

// ===== hdl/csa_cell.sv =====
// One slot cell of the rotating free-map ring.
module csa_cell
  import csa_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic shift_i,
  input  logic free_i,
  output logic free_o
);

  logic free_q, free_d;

  always_comb begin
    free_d = free_q;
    if (shift_i) begin
      free_d = free_i;
    end
  end

  // Slots come out of reset free.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_q <= 1'b1;
    end else begin
      free_q <= free_d;
    end
  end

  assign free_o = free_q;

endmodule

// ===== hdl/csa_div.sv =====
// Restoring divider, one quotient bit per cycle.
module csa_div
  import csa_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic [BytesW-1:0]  quot_q, quot_d;
  logic [SizeW:0]     rem_q, rem_d;
  logic [SizeW-1:0]   dsr_q, dsr_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [SizeW:0]     rem_sh;
  logic [SizeW:0]     rem_sub;
  logic               fits;

  assign rem_sh  = {rem_q[SizeW-1:0], quot_q[BytesW-1]};
  assign rem_sub = rem_sh - {1'b0, dsr_q};
  assign fits    = rem_sh >= {1'b0, dsr_q};

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      quot_d = req_i.dividend;
      rem_d  = '0;
      dsr_d  = req_i.divisor;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d  = fits ? rem_sub : rem_sh;
      quot_d = {quot_q[BytesW-2:0], fits};
      cnt_d  = cnt_q + DivCntW'(1);
      if (cnt_q == DivCntW'(BytesW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dsr_q  <= dsr_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;
  assign rsp_o.rem  = rem_q[SizeW-1:0];

endmodule

// ===== hdl/contiguous_slot_allocator.sv =====
// Top level of the first-fit contiguous slot allocator.
// The 64-slot free map lives in a ring of cells that rotates one slot per
// cycle, while searching or marking, past a single head position. An item
// is taken only while the block is idle; the byte count is divided by the
// slot size in the restoring divider, then an allocate of at most 64 slots
// spends one rotation searching for the first fit and, on success with a
// nonzero size, a second rotation marking the run used, while a valid free
// spends one rotation marking its run free. The result sits in an output
// register, so the next item may be accepted while it waits. There is no
// clearing pass: the cells come out of reset all free.
`include "contiguous_slot_allocator_assert.svh"

module contiguous_slot_allocator
  import csa_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [SizeW-1:0]  cfg_wdata_i,      // slot_size_bytes
  input  logic              s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  logic [23:0]       s_axis_tdata_i,   // request_bytes[17:0], start_slot[23:18]
  input  logic              s_axis_tuser_i,   // opcode
  output logic              m_axis_tvalid_o,
  input  logic              m_axis_tready_i,
  output logic [23:0]       m_axis_tdata_o,   // granted_slot[5:0], granted_bytes[23:6]
  output logic [1:0]        m_axis_tuser_o    // status
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_DIV   = 6'b000010,
    ST_CHECK = 6'b000100,
    ST_SCAN  = 6'b001000,
    ST_MARK  = 6'b010000,
    ST_OUT   = 6'b100000
  } state_e;

  state_e            state_q, state_d;
  logic [SizeW-1:0]  size_cfg_q;
  logic [SizeW-1:0]  size_eff;

  logic              op_q, op_d;
  logic [SlotW-1:0]  start_q, start_d;
  logic [CntW-1:0]   need_q, need_d;
  logic [CntW-1:0]   target_q, target_d;
  logic [CntW-1:0]   run_q, run_d;
  logic              found_q, found_d;
  logic [SlotW-1:0]  hit_q, hit_d;
  logic              mark_val_q, mark_val_d;
  logic [SlotW-1:0]  mark_lo_q, mark_lo_d;
  logic [CntW-1:0]   mark_cnt_q, mark_cnt_d;
  logic [ProdW-1:0]  prod_q, prod_d;
  logic [SlotW-1:0]  idx_q, idx_d;
  status_e           res_status_q, res_status_d;
  logic [SlotW-1:0]  res_slot_q, res_slot_d;
  logic [BytesW-1:0] res_bytes_q, res_bytes_d;

  logic              m_valid_q, m_valid_d;
  status_e           m_status_q, m_status_d;
  logic [SlotW-1:0]  m_slot_q, m_slot_d;
  logic [BytesW-1:0] m_bytes_q, m_bytes_d;

  div_req_t          div_req;
  div_rsp_t          div_rsp;

  logic [NumSlots-1:0] ring_bit;
  logic              shift_en;
  logic              head;
  logic              head_new;
  logic              in_range;
  logic              in_accept;
  logic [BytesW:0]   need_full;
  logic [CntW-1:0]   free_lim;
  logic              free_bad;
  logic [CntW-1:0]   run_inc;
  logic [CntW-1:0]   hit_calc;
  logic [BytesW-1:0] bytes_sat;

  // Out-of-range register values clamp to the legal slot sizes.
  always_comb begin
    size_eff = size_cfg_q;
    if (size_cfg_q < SizeMin) begin
      size_eff = SizeMin;
    end else if (size_cfg_q > SizeMax) begin
      size_eff = SizeMax;
    end
  end

  assign in_accept = s_axis_tvalid_i && s_axis_tready_o;

  assign div_req.start    = in_accept;
  assign div_req.dividend = s_axis_tdata_i[BytesW-1:0];
  assign div_req.divisor  = size_eff;

  csa_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Ring rotates toward slot 0; the head value re-enters at the far end.
  assign shift_en = (state_q == ST_SCAN) || (state_q == ST_MARK);
  assign head     = ring_bit[0];
  assign in_range = ({1'b0, idx_q} >= {1'b0, mark_lo_q}) &&
                    ({1'b0, idx_q} < ({1'b0, mark_lo_q} + mark_cnt_q));
  assign head_new = ((state_q == ST_MARK) && in_range) ? mark_val_q : head;

  for (genvar k = 0; k < NumSlots; k++) begin : g_cell
    logic cell_in;
    if (k == NumSlots - 1) begin : g_tail
      assign cell_in = head_new;
    end else begin : g_body
      assign cell_in = ring_bit[k+1];
    end
    csa_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (shift_en),
      .free_i  (cell_in),
      .free_o  (ring_bit[k])
    );
  end

  assign need_full = {1'b0, div_rsp.quot} + (BytesW+1)'(div_rsp.rem != '0);
  assign free_lim  = CntW'(NumSlots) - {1'b0, start_q};
  assign free_bad  = (div_rsp.rem != '0) ||
                     ({1'b0, start_q} >= CntW'(NumSlots)) ||
                     (div_rsp.quot > BytesW'(free_lim));
  assign run_inc   = run_q + CntW'(1);
  assign hit_calc  = {1'b0, idx_q} + CntW'(1) - target_q;
  assign bytes_sat = (prod_q > ProdW'(BytesMax)) ? BytesMax : prod_q[BytesW-1:0];

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    start_d      = start_q;
    need_d       = need_q;
    target_d     = target_q;
    run_d        = run_q;
    found_d      = found_q;
    hit_d        = hit_q;
    mark_val_d   = mark_val_q;
    mark_lo_d    = mark_lo_q;
    mark_cnt_d   = mark_cnt_q;
    prod_d       = prod_q;
    idx_d        = idx_q;
    res_status_d = res_status_q;
    res_slot_d   = res_slot_q;
    res_bytes_d  = res_bytes_q;
    m_valid_d    = m_valid_q;
    m_status_d   = m_status_q;
    m_slot_d     = m_slot_q;
    m_bytes_d    = m_bytes_q;

    if (m_valid_q && m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          op_d    = s_axis_tuser_i;
          start_d = s_axis_tdata_i[BytesW+SlotW-1:BytesW];
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        idx_d       = '0;
        run_d       = '0;
        found_d     = 1'b0;
        res_slot_d  = '0;
        res_bytes_d = '0;
        if (op_q == OP_ALLOC) begin
          if (need_full > (BytesW+1)'(NumSlots)) begin
            res_status_d = STATUS_NO_ROOM;
            state_d      = ST_OUT;
          end else begin
            need_d = need_full[CntW-1:0];
            // A zero-byte request searches for the first single free slot.
            target_d = (need_full == '0) ? CntW'(1) : need_full[CntW-1:0];
            state_d  = ST_SCAN;
          end
        end else begin
          if (free_bad) begin
            res_status_d = STATUS_BAD_FREE;
            state_d      = ST_OUT;
          end else begin
            res_status_d = STATUS_DONE;
            mark_val_d   = 1'b1;
            mark_lo_d    = start_q;
            mark_cnt_d   = div_rsp.quot[CntW-1:0];
            state_d      = ST_MARK;
          end
        end
      end
      ST_SCAN: begin
        idx_d  = idx_q + SlotW'(1);
        run_d  = head ? run_inc : '0;
        prod_d = ProdW'(need_q) * ProdW'(size_eff);
        if (!found_q && head && (run_inc == target_q)) begin
          found_d = 1'b1;
          hit_d   = hit_calc[SlotW-1:0];
        end
        if (idx_q == SlotW'(NumSlots - 1)) begin
          if (found_d) begin
            res_status_d = STATUS_DONE;
            res_slot_d   = hit_d;
            if (need_q == '0) begin
              res_bytes_d = '0;
              state_d     = ST_OUT;
            end else begin
              res_bytes_d = bytes_sat;
              mark_val_d  = 1'b0;
              mark_lo_d   = hit_d;
              mark_cnt_d  = need_q;
              state_d     = ST_MARK;
            end
          end else begin
            res_status_d = STATUS_NO_ROOM;
            res_slot_d   = '0;
            res_bytes_d  = '0;
            state_d      = ST_OUT;
          end
        end
      end
      ST_MARK: begin
        idx_d = idx_q + SlotW'(1);
        if (idx_q == SlotW'(NumSlots - 1)) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!m_valid_q || m_axis_tready_i) begin
          m_valid_d  = 1'b1;
          m_status_d = res_status_q;
          m_slot_d   = res_slot_q;
          m_bytes_d  = res_bytes_q;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      size_cfg_q <= SizeReset;
      m_valid_q  <= 1'b0;
      run_q      <= '0;
      found_q    <= 1'b0;
      idx_q      <= '0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
      run_q     <= run_d;
      found_q   <= found_d;
      idx_q     <= idx_d;
      if (cfg_we_i) begin
        size_cfg_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    start_q      <= start_d;
    need_q       <= need_d;
    target_q     <= target_d;
    hit_q        <= hit_d;
    mark_val_q   <= mark_val_d;
    mark_lo_q    <= mark_lo_d;
    mark_cnt_q   <= mark_cnt_d;
    prod_q       <= prod_d;
    res_status_q <= res_status_d;
    res_slot_q   <= res_slot_d;
    res_bytes_q  <= res_bytes_d;
    m_status_q   <= m_status_d;
    m_slot_q     <= m_slot_d;
    m_bytes_q    <= m_bytes_d;
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {m_bytes_q, m_slot_q};
  assign m_axis_tuser_o  = m_status_q;

  `CSA_ASSERT_NEXT(a_busy_after_accept, in_accept, !s_axis_tready_o,
    "input taken while an item is still in progress")
  `CSA_ASSERT(a_status_legal, m_axis_tvalid_o |-> (m_axis_tuser_o != 2'd3),
    "result carries an undefined status code")
  `CSA_ASSERT(a_fail_zero, (m_axis_tvalid_o && (m_axis_tuser_o != STATUS_DONE)) |->
    (m_axis_tdata_o == '0), "failed request reports a nonzero slot or size")
  `CSA_ASSERT_NEXT(a_scan_ends, (state_q == ST_SCAN) && (idx_q == SlotW'(NumSlots - 1)),
    state_q != ST_SCAN, "search did not stop after one full rotation")

endmodule
